// ===== rtl/skt_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// skt_pkg
// Shared types, constants and microcode for the scalar Kalman tracker.
// ---------------------------------------------------------------------------
package skt_pkg;

  localparam int CfgIndexW = 3;
  localparam int StepW     = 4;
  localparam int DivCntW   = 5;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegProcessNoise     = 3'd0;
  localparam logic [CfgIndexW-1:0] RegMeasurementNoise = 3'd1;
  localparam logic [CfgIndexW-1:0] RegTimeStep         = 3'd2;
  localparam logic [CfgIndexW-1:0] RegInitialPosition  = 3'd3;
  localparam logic [CfgIndexW-1:0] RegInitialVariance  = 3'd4;

  // Reset values
  localparam logic [31:0]        ProcessNoiseRst     = 32'd1311;
  localparam logic [31:0]        MeasurementNoiseRst = 32'd32768;
  localparam logic [15:0]        TimeStepRst         = 16'd6554;
  localparam logic signed [31:0] InitialPositionRst  = 32'sd0;
  localparam logic [31:0]        InitialVarianceRst  = 32'd65536;
  localparam logic [31:0]        VarianceRst         = 32'd65536;

  localparam logic [16:0] OneQ16  = 17'h10000;
  localparam logic [15:0] GainMax = 16'hFFFF;

  // Last divider iteration: 17 quotient bits, counted 0..16
  localparam logic [DivCntW-1:0] DivLast = 5'd16;

  typedef struct packed {
    logic [31:0]        process_noise;
    logic [31:0]        measurement_noise;
    logic [15:0]        time_step;
    logic signed [31:0] initial_position;
    logic [31:0]        initial_variance;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MUL_VEL,
    OP_PREDICT,
    OP_DIV,
    OP_GAIN,
    OP_MUL_CORR,
    OP_CORRECT,
    OP_MUL_VAR,
    OP_VARIANCE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [StepW-1:0] target;
    logic             last;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic out_busy;
    logic div_more;
  } seq_status_t;

  localparam logic [StepW-1:0] StepIdle = 4'd0;
  localparam logic [StepW-1:0] StepDiv  = 4'd3;
  localparam logic [StepW-1:0] StepEmit = 4'd9;

  // Microprogram: one control word per step
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = '{op: OP_IDLE, cond: C_ALWAYS, target: StepIdle, last: 1'b0};
    case (step)
      4'd0: w = '{op: OP_IDLE,     cond: C_NO_START, target: StepIdle, last: 1'b0};
      4'd1: w = '{op: OP_MUL_VEL,  cond: C_NEVER,    target: StepIdle, last: 1'b0};
      4'd2: w = '{op: OP_PREDICT,  cond: C_NEVER,    target: StepIdle, last: 1'b0};
      4'd3: w = '{op: OP_DIV,      cond: C_DIV_MORE, target: StepDiv,  last: 1'b0};
      4'd4: w = '{op: OP_GAIN,     cond: C_NEVER,    target: StepIdle, last: 1'b0};
      4'd5: w = '{op: OP_MUL_CORR, cond: C_NEVER,    target: StepIdle, last: 1'b0};
      4'd6: w = '{op: OP_CORRECT,  cond: C_NEVER,    target: StepIdle, last: 1'b0};
      4'd7: w = '{op: OP_MUL_VAR,  cond: C_NEVER,    target: StepIdle, last: 1'b0};
      4'd8: w = '{op: OP_VARIANCE, cond: C_NEVER,    target: StepIdle, last: 1'b0};
      4'd9: w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: StepEmit, last: 1'b1};
      default: w = '{op: OP_IDLE, cond: C_ALWAYS, target: StepIdle, last: 1'b0};
    endcase
    return w;
  endfunction

  // Saturate a 36-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/skt_in_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// skt_in_if
// Input channel: restart flag, velocity and measurement.
// ---------------------------------------------------------------------------
interface skt_in_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [31:0] velocity;
  logic signed [31:0] measurement;

  modport source (output valid, output restart, output velocity, output measurement,
                  input ready);
  modport sink   (input valid, input restart, input velocity, input measurement,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/skt_out_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// skt_out_if
// Result channel: corrected estimate and its variance.
// ---------------------------------------------------------------------------
interface skt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate;
  logic [31:0]        uncertainty;

  modport source (output valid, output estimate, output uncertainty, input ready);
  modport sink   (input valid, input estimate, input uncertainty, output ready);
endinterface
`default_nettype wire

// ===== rtl/skt_cfg_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// skt_cfg_if
// Configuration write channel: register index and data.
// ---------------------------------------------------------------------------
interface skt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/skt_sequencer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// skt_sequencer
// Step counter over the microcode ROM with conditional jumps.
// ---------------------------------------------------------------------------
module skt_sequencer
  import skt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire seq_status_t status,
  output ucode_t           word
);

  logic [StepW-1:0] step;
  logic [StepW-1:0] step_next;
  logic             taken;

  assign word = ucode_rom(step);

  always_comb begin
    case (word.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_START: taken = !status.start;
      C_DIV_MORE: taken = status.div_more;
      C_OUT_BUSY: taken = status.out_busy;
      default:    taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      step_next = word.target;
    end else if (word.last) begin
      step_next = StepIdle;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= StepIdle;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/skt_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// skt_datapath
// State, shared multiplier, restoring divider step and result register.
// ---------------------------------------------------------------------------
module skt_datapath
  import skt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ucode_t             word,
  input  wire cfg_regs_t          cfg,
  input  wire logic               in_valid,
  input  wire logic               in_restart,
  input  wire logic signed [31:0] in_velocity,
  input  wire logic signed [31:0] in_measurement,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_estimate,
  output logic [31:0]             out_uncertainty,
  output seq_status_t             status
);

  logic signed [31:0] vel;
  logic signed [31:0] meas;
  logic signed [31:0] pos;
  logic [31:0]        var_q;
  logic signed [31:0] x;
  logic [31:0]        p;
  logic [32:0]        d;
  logic [33:0]        rem;
  logic [16:0]        q;
  logic [15:0]        k;
  logic signed [32:0] diff;
  logic signed [51:0] prod;
  logic [DivCntW-1:0] cnt;

  logic               in_fire;
  logic               out_busy;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod_rnd;
  logic signed [35:0] rnd;
  logic [32:0]        p_sum;
  logic               ge;
  logic [33:0]        rem_sub;

  assign in_ready = (word.op == OP_IDLE);
  assign in_fire  = in_ready && in_valid;
  assign out_busy = out_valid && !out_ready;

  assign status.start    = in_valid;
  assign status.out_busy = out_busy;
  assign status.div_more = (cnt != DivLast);

  // Shared multiplier operand select
  always_comb begin
    case (word.op)
      OP_MUL_VEL: begin
        mul_a = {{2{vel[31]}}, vel};
        mul_b = {2'b00, cfg.time_step};
      end
      OP_MUL_CORR: begin
        mul_a = {diff[32], diff};
        mul_b = {2'b00, k};
      end
      OP_MUL_VAR: begin
        mul_a = {2'b00, p};
        mul_b = {1'b0, OneQ16 - {1'b0, k}};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round to nearest, ties up: floor((prod + 0.5) / 2^16)
  assign prod_rnd = prod + 52'sd32768;
  assign rnd      = prod_rnd[51:16];

  assign p_sum   = {1'b0, var_q} + {1'b0, cfg.process_noise};
  assign ge      = (rem >= {1'b0, d});
  assign rem_sub = ge ? (rem - {1'b0, d}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= InitialPositionRst;
      var_q     <= VarianceRst;
      out_valid <= 1'b0;
    end else begin
      if (word.op == OP_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (word.op)
        OP_IDLE: begin
          if (in_fire && in_restart) begin
            pos   <= cfg.initial_position;
            var_q <= cfg.initial_variance;
          end
        end
        OP_CORRECT:  pos   <= sat_s32({{4{x[31]}}, x} + rnd);
        OP_VARIANCE: var_q <= rnd[31:0];
        default: ;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    case (word.op)
      OP_IDLE: begin
        if (in_fire) begin
          vel  <= in_velocity;
          meas <= in_measurement;
        end
      end
      OP_MUL_VEL: begin
        prod <= mul_a * mul_b;
        p    <= p_sum[32] ? 32'hFFFFFFFF : p_sum[31:0];
      end
      OP_PREDICT: begin
        x   <= sat_s32({{4{pos[31]}}, pos} + rnd);
        d   <= {1'b0, p} + {1'b0, cfg.measurement_noise};
        rem <= {2'b00, p};
        q   <= '0;
        cnt <= '0;
      end
      OP_DIV: begin
        rem <= {rem_sub[32:0], 1'b0};
        q   <= {q[15:0], ge};
        cnt <= cnt + 1'b1;
      end
      OP_GAIN: begin
        if (d == '0) begin
          k <= '0;
        end else if (q[16]) begin
          k <= GainMax;
        end else begin
          k <= q[15:0];
        end
        diff <= {meas[31], meas} - {x[31], x};
      end
      OP_MUL_CORR: prod <= mul_a * mul_b;
      OP_MUL_VAR:  prod <= mul_a * mul_b;
      OP_EMIT: begin
        if (!out_busy) begin
          out_estimate    <= pos;
          out_uncertainty <= var_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/scalar_kalman_tracker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// scalar_kalman_tracker
// Scalar fixed-point Kalman position tracker run by a microcoded sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   req : one transaction per sensor ping (restart, velocity, measurement).
//         restart = 1 reloads position/variance from the initial-value
//         registers before the predict step.
//   rsp : one transaction per ping carrying the corrected estimate (signed
//         Q16.16) and its variance (unsigned Q16.16).
//   cfg : register writes, index 0..4 = process noise, measurement noise,
//         time step, initial position, initial variance; other indexes are
//         dropped. Always ready. Write only while the tracker is idle.
// Sequence:
//   Each req runs through predict, the gain divider loop (17 quotient bits),
//   correction and variance update, using three passes through the shared
//   34x18 multiplier; a new req is taken only once the result is emitted.
//   req.ready is high only while the sequencer sits in its idle step.
// Reset (rst, synchronous): position 0, variance 1.0, registers to defaults,
//   no result pending.
// Stall: the result register holds while rsp.ready is low; the next req can
//   be taken and computed meanwhile, the sequencer then waits at its final
//   step until the result register frees up.
// ---------------------------------------------------------------------------
module scalar_kalman_tracker
  import skt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  skt_in_if.sink    req,
  skt_out_if.source rsp,
  skt_cfg_if.sink   cfg
);

  cfg_regs_t   regs;
  ucode_t      word;
  seq_status_t status;

  // Configuration registers, written on any cfg transaction to index 0..4
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.process_noise     <= ProcessNoiseRst;
      regs.measurement_noise <= MeasurementNoiseRst;
      regs.time_step         <= TimeStepRst;
      regs.initial_position  <= InitialPositionRst;
      regs.initial_variance  <= InitialVarianceRst;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        RegProcessNoise:     regs.process_noise     <= cfg.data;
        RegMeasurementNoise: regs.measurement_noise <= cfg.data;
        RegTimeStep:         regs.time_step         <= cfg.data[15:0];
        RegInitialPosition:  regs.initial_position  <= cfg.data;
        RegInitialVariance:  regs.initial_variance  <= cfg.data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Step counter and microcode ROM
  skt_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .word   (word)
  );

  // Arithmetic, state and result register
  skt_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .word            (word),
    .cfg             (regs),
    .in_valid        (req.valid),
    .in_restart      (req.restart),
    .in_velocity     (req.velocity),
    .in_measurement  (req.measurement),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_estimate    (rsp.estimate),
    .out_uncertainty (rsp.uncertainty),
    .status          (status)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the scalar Kalman tracker. A transaction-level tracking
// model predicts every estimate/variance pair. Directed cases hit reset
// state, saturation, zero divisor, unit gain and dropped register writes.
// Random traffic then runs in three backpressure phases.
// ---------------------------------------------------------------------------
module testbench
  import skt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned BlockItems  = 100;        // random pings per settings block
  localparam int unsigned BlockCount  = 4;          // settings blocks per phase

  // One expected result transaction
  typedef struct packed {
    logic signed [31:0] estimate;
    logic [31:0]        uncertainty;
  } fix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skt_in_if  req_if ();
  skt_out_if rsp_if ();
  skt_cfg_if cfg_if ();

  scalar_kalman_tracker dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tracking model: register shadow, filter state and pending results
  // ---------------------------------------------------------------------------
  cfg_regs_t          shadow_cfg;
  logic signed [31:0] track_pos;
  logic [31:0]        track_var;
  fix_t               fix_queue[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // Shift right by 16 with round to nearest, ties toward +inf. An arithmetic
  // shift of x+0.5 is exactly floor(x+0.5) for either sign.
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Mirror of a register write; unknown indexes are dropped like in the DUT
  function automatic void shadow_write(input logic [CfgIndexW-1:0] idx,
                                       input logic [31:0] data);
    case (idx)
      RegProcessNoise:     shadow_cfg.process_noise     = data;
      RegMeasurementNoise: shadow_cfg.measurement_noise = data;
      RegTimeStep:         shadow_cfg.time_step         = data[15:0];
      RegInitialPosition:  shadow_cfg.initial_position  = data;
      RegInitialVariance:  shadow_cfg.initial_variance  = data;
      default: ;
    endcase
  endfunction

  // One predict + update step; queues the expected result transaction
  function automatic void track_step(input logic rs, input logic signed [31:0] vel,
                                     input logic signed [31:0] meas);
    longint vel_l, meas_l, dt_l, x, p, denom, gain, corr, pvar;
    fix_t   fx;
    if (rs) begin
      track_pos = shadow_cfg.initial_position;
      track_var = shadow_cfg.initial_variance;
    end
    vel_l  = vel;
    meas_l = meas;
    dt_l   = shadow_cfg.time_step;
    // predict: x += v*dt (Q16.32 rounded back), P += Q saturating
    x = track_pos;
    x = clamp_s32(x + round_q16(vel_l * dt_l));
    p = track_var;
    p = p + shadow_cfg.process_noise;
    if (p > 64'sh0FFFFFFFF) p = 64'sh0FFFFFFFF;
    // gain K = P/(P+R) in Q0.16; zero divisor gives 0, unit gain clips
    denom = p + shadow_cfg.measurement_noise;
    if (denom == 0) begin
      gain = 0;
    end else begin
      gain = (p << 16) / denom;
      if (gain > GainMax) gain = GainMax;
    end
    // update position and variance
    corr      = round_q16(gain * (meas_l - x));
    track_pos = clamp_s32(x + corr);
    pvar      = (p * (OneQ16 - gain) + 64'sd32768) >>> 16;
    if (pvar > 64'sh0FFFFFFFF) pvar = 64'sh0FFFFFFFF;
    track_var = pvar[31:0];
    fx.estimate    = track_pos;
    fx.uncertainty = track_var;
    fix_queue.push_back(fx);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure plus the scoreboard check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    fix_t want;
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (fix_queue.size() == 0) begin
        $error("unexpected result transaction: estimate %0d uncertainty %0d",
               rsp_if.estimate, rsp_if.uncertainty);
        fail_count++;
      end else begin
        want = fix_queue.pop_front();
        if (rsp_if.estimate !== want.estimate) begin
          $error("estimate mismatch: expected %0d, actual %0d",
                 want.estimate, rsp_if.estimate);
          fail_count++;
        end
        if (rsp_if.uncertainty !== want.uncertainty) begin
          $error("uncertainty mismatch: expected %0d, actual %0d",
                 want.uncertainty, rsp_if.uncertainty);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks return at a rising edge; send_ping and write_reg
  // leave their valid high so that back-to-back items never pulse it low.
  // ---------------------------------------------------------------------------

  // One ping transaction, with a random gap before it
  task automatic send_ping(input logic rs, input logic signed [31:0] vel,
                           input logic signed [31:0] meas);
    while ($urandom_range(99) < send_idle_pct) begin
      if (req_if.valid) req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.restart     <= rs;
    req_if.velocity    <= vel;
    req_if.measurement <= meas;
    do @(posedge clk); while (!req_if.ready);
    track_step(rs, vel, meas);
  endtask

  // One register write transaction
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    shadow_write(idx, data);
  endtask

  // Stop sending and wait for every pending result; the tracker is idle after
  task automatic wait_drained();
    if (req_if.valid) req_if.valid <= 1'b0;
    while (fix_queue.size() != 0) @(posedge clk);
  endtask

  // Full register load, only called once drained
  task automatic apply_settings(input cfg_regs_t s);
    write_reg(RegProcessNoise,     s.process_noise);
    write_reg(RegMeasurementNoise, s.measurement_noise);
    write_reg(RegTimeStep,         {16'h0000, s.time_step});
    write_reg(RegInitialPosition,  s.initial_position);
    write_reg(RegInitialVariance,  s.initial_variance);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic cfg_regs_t make_settings(input logic [31:0] q, input logic [31:0] r,
                                              input logic [15:0] dt,
                                              input logic signed [31:0] x0,
                                              input logic [31:0] p0);
    cfg_regs_t s;
    s.process_noise     = q;
    s.measurement_noise = r;
    s.time_step         = dt;
    s.initial_position  = x0;
    s.initial_variance  = p0;
    return s;
  endfunction

  // Word with heavy weight on corner values
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h00000000;
      1:       return 32'hFFFFFFFF;
      2:       return 32'h80000000;
      3:       return 32'h7FFFFFFF;
      default: return $urandom();
    endcase
  endfunction

  // Variance-like register: mostly small, sometimes zero, max or anything
  function automatic logic [31:0] pick_noise(input int unsigned span);
    case ($urandom_range(9))
      0:       return 32'h00000000;
      1:       return 32'hFFFFFFFF;
      2:       return $urandom();
      default: return $urandom_range(span, 1);
    endcase
  endfunction

  function automatic cfg_regs_t random_settings();
    logic [15:0]        dt;
    logic signed [31:0] x0;
    case ($urandom_range(5))
      0:       dt = 16'h0000;
      1:       dt = 16'hFFFF;
      default: dt = $urandom_range(65535);
    endcase
    case ($urandom_range(5))
      0:       x0 = pick_word();
      1:       x0 = $urandom();
      default: x0 = $signed($urandom_range(1 << 24)) - (1 << 23);
    endcase
    return make_settings(pick_noise(1 << 16), pick_noise(1 << 20), dt, x0,
                         pick_noise(1 << 18));
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset values of state and registers, then a restart with defaults
  task automatic test_reset_state();
    send_ping(1'b0, 32'sd0, 32'sd0);
    send_ping(1'b0, 32'sh00010000, 32'sh00008000);
    send_ping(1'b1, -32'sd65536, 32'sd12345);
  endtask

  // Position saturation at both rails, largest and smallest time step
  task automatic test_position_extremes();
    wait_drained();
    apply_settings(make_settings(32'd1311, 32'd32768, 16'hFFFF, 32'sh7FFFFFFF, 32'd65536));
    send_ping(1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);  // pinned at the top rail
    send_ping(1'b0, 32'sh80000000, 32'sh80000000);
    send_ping(1'b0, 32'sh80000000, 32'sh80000000);  // drive toward the bottom rail
    send_ping(1'b0, 32'sh7FFFFFFF, 32'sh80000000);
    wait_drained();
    apply_settings(make_settings(32'd0, 32'd1, 16'h0000, 32'sh80000000, 32'd65536));
    send_ping(1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);  // dt of zero: velocity ignored
    send_ping(1'b0, 32'sh80000000, 32'sh80000000);
  endtask

  // Variance sum clipping at all ones
  task automatic test_variance_saturation();
    wait_drained();
    apply_settings(make_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 16'd6554, 32'sd0, 32'hFFFFFFFF));
    send_ping(1'b1, 32'sd0, 32'sh7FFFFFFF);
    send_ping(1'b0, 32'sd65536, 32'sh80000000);
    send_ping(1'b0, -32'sd1, 32'sd0);
  endtask

  // P+R of zero: gain forced to zero, variance stays zero
  task automatic test_zero_divisor();
    wait_drained();
    apply_settings(make_settings(32'd0, 32'd0, 16'd6554, 32'sh00050000, 32'd0));
    send_ping(1'b1, 32'sh00010000, 32'sh7FFFFFFF);
    send_ping(1'b0, -32'sh00010000, 32'sh80000000);
    send_ping(1'b0, 32'sd0, 32'sd0);
  endtask

  // Zero measurement noise: gain clips just below one
  task automatic test_unit_gain();
    wait_drained();
    apply_settings(make_settings(32'd1311, 32'd0, 16'd6554, -32'sh00030000, 32'd65536));
    send_ping(1'b1, 32'sh00020000, 32'sh00100000);
    send_ping(1'b0, 32'sd0, 32'sh80000000);
    send_ping(1'b0, 32'sd0, 32'sh7FFFFFFF);
  endtask

  // Writes to indexes past the register file must change nothing
  task automatic test_unknown_index();
    int i;
    wait_drained();
    for (i = int'(RegInitialVariance) + 1; i < (1 << CfgIndexW); i++) begin
      write_reg(i[CfgIndexW-1:0], (i % 2 == 0) ? 32'hFFFFFFFF : $urandom());
    end
    cfg_if.valid <= 1'b0;
    send_ping(1'b1, 32'sh00010000, 32'sh00020000);
    send_ping(1'b0, 32'sh00010000, 32'sh00020000);
  endtask

  // ---------------------------------------------------------------------------
  // Random tracking traffic. Most pings follow the current estimate with
  // modest velocity and sensor noise so the filter converges; the rest are
  // corner-heavy raw words. Restarts are sprinkled in.
  // ---------------------------------------------------------------------------
  task automatic test_random_tracking(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned        blk, n;
    logic               rs;
    logic signed [31:0] vel, meas;
    longint             aim;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (blk = 0; blk < BlockCount; blk++) begin
      wait_drained();
      apply_settings(random_settings());
      for (n = 0; n < BlockItems; n++) begin
        rs = ($urandom_range(24) == 0);
        if ($urandom_range(99) < 75) begin
          aim  = rs ? shadow_cfg.initial_position : track_pos;
          aim  = aim + ($signed($urandom_range(1 << 19)) - (1 << 18));
          vel  = $signed($urandom_range(1 << 21)) - (1 << 20);
          meas = clamp_s32(aim);
        end else begin
          vel  = pick_word();
          meas = pick_word();
        end
        send_ping(rs, vel, meas);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_if.valid       <= 1'b0;
    req_if.restart     <= 1'b0;
    req_if.velocity    <= '0;
    req_if.measurement <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= RegProcessNoise;
    cfg_if.data        <= '0;

    shadow_cfg = make_settings(ProcessNoiseRst, MeasurementNoiseRst, TimeStepRst,
                               InitialPositionRst, InitialVarianceRst);
    track_pos  = '0;
    track_var  = VarianceRst;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_position_extremes();
    test_variance_saturation();
    test_zero_divisor();
    test_unit_gain();
    test_unknown_index();

    test_random_tracking(35, 87);   // slow consumer
    test_random_tracking(87, 35);   // slow producer
    test_random_tracking(0, 0);     // full rate

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== scalar_kalman_tracker.f =====
rtl/skt_pkg.sv
rtl/skt_in_if.sv
rtl/skt_out_if.sv
rtl/skt_cfg_if.sv
rtl/skt_sequencer.sv
rtl/skt_datapath.sv
rtl/scalar_kalman_tracker.sv
bench/testbench.sv
